// ===== design/rgbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbc_pkg: shared types and constants of the rgb 3x3 convolution filter
// Sizes, register codes, queue job format and a size helper function.
// ----------------------------------------------------------------------------
package rgbc_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int COEF_FRAC_BITS = 12;
    localparam int CHAN_MAX       = 255;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int COORD_W = 10;
    localparam int DIM_W   = 11;
    localparam int COEF_W  = 48;
    localparam int WGT_W   = 16;
    localparam int PIX_W   = 24;
    localparam int PROD_W  = 25;
    localparam int SUM_W   = 28;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [2:0] REG_COEF_TOP = 3'd0;
    localparam logic [2:0] REG_COEF_MID = 3'd1;
    localparam logic [2:0] REG_COEF_BOT = 3'd2;
    localparam logic [2:0] REG_WIDTH    = 3'd3;
    localparam logic [2:0] REG_HEIGHT   = 3'd4;

    localparam logic [COEF_W-1:0] COEF_TOP_RST = 48'd1099545182464;
    localparam logic [COEF_W-1:0] COEF_MID_RST = 48'd2199090364928;
    localparam logic [COEF_W-1:0] COEF_BOT_RST = 48'd1099545182464;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic [2:0][COEF_W-1:0] coef;
        logic [DIM_W-1:0]       width;
        logic [DIM_W-1:0]       height;
    } cfg_t;

    typedef struct packed {
        pixel_t [8:0]     win;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             interior;
        logic             border;
        logic             frame_last;
    } job_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== design/rgbc_ram.sv =====
// ----------------------------------------------------------------------------
// rgbc_ram: generic single-write, single-read ram
// One write port and one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module rgbc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/rgbc_queue.sv =====
// ----------------------------------------------------------------------------
// rgbc_queue: job queue between front and back
// Small register fifo of window jobs; head is read at the read pointer.
// ----------------------------------------------------------------------------
module rgbc_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  rgbc_pkg::job_t            push_job,
    input  logic                      pop,
    output rgbc_pkg::job_t            head_job,
    output logic [rgbc_pkg::QPTR_W:0] count
);
    import rgbc_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

    assign head_job = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

endmodule

// ===== design/rgbc_front.sv =====
// ----------------------------------------------------------------------------
// rgbc_front: pixel intake, raster position and line buffers
// Classifies each pixel, builds the 3x3 window and queues a job for it.
// ----------------------------------------------------------------------------
module rgbc_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rgbc_pkg::cfg_t            cfg,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,
    input  logic [rgbc_pkg::QPTR_W:0] q_count,
    output logic                      push,
    output rgbc_pkg::job_t            push_job
);
    import rgbc_pkg::*;

    logic [DIM_W-1:0] w_eff, h_eff, x_cur, y_wrap, y_cur;
    logic             x_last, y_last, accept;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             a_valid_reg, a_int_reg, a_bor_reg, a_fl_reg;
    logic [COL_W-1:0] a_x_reg;
    logic [ROW_W-1:0] a_y_reg;
    pixel_t           a_px_reg;
    logic             fwd_reg;
    pixel_t           fwd_old_reg, fwd_new_reg;
    pixel_t           old_dout, new_dout, above2, above1;
    pixel_t [8:0]     win_reg, win_next;

    assign w_eff = eff_dim(cfg.width, DIM_W'(MAX_WIDTH));
    assign h_eff = eff_dim(cfg.height, DIM_W'(MAX_HEIGHT));

    assign s_tready = (q_count + (QPTR_W+1)'(a_valid_reg)) < (QPTR_W+1)'(QDEPTH);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if ({1'b0, col_reg} >= w_eff) begin
            x_cur  = '0;
            y_wrap = {1'b0, row_reg} + DIM_W'(1);
        end else begin
            x_cur  = {1'b0, col_reg};
            y_wrap = {1'b0, row_reg};
        end
        y_cur  = (y_wrap >= h_eff) ? '0 : y_wrap;
        x_last = (x_cur + DIM_W'(1)) >= w_eff;
        y_last = (y_cur + DIM_W'(1)) >= h_eff;
        if (x_last) begin
            col_next = '0;
            row_next = y_last ? '0 : ROW_W'(y_cur + DIM_W'(1));
        end else begin
            col_next = COL_W'(x_cur + DIM_W'(1));
            row_next = ROW_W'(y_cur);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end else begin
            a_valid_reg <= accept;
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
                fwd_reg <= a_valid_reg && (a_x_reg == COL_W'(x_cur));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_x_reg     <= COL_W'(x_cur);
            a_y_reg     <= ROW_W'(y_cur);
            a_px_reg    <= s_tdata;
            a_int_reg   <= (y_cur >= DIM_W'(2)) && (x_cur >= DIM_W'(2));
            a_bor_reg   <= (y_cur == '0) || (x_cur == '0) || y_last || x_last;
            a_fl_reg    <= x_last && y_last;
            fwd_old_reg <= above1;
            fwd_new_reg <= a_px_reg;
        end
    end

    // rows y-2 and y-1 at the current column
    rgbc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
        .aclk  (aclk),
        .we    (a_valid_reg),
        .waddr (a_x_reg),
        .wdata (above1),
        .re    (accept),
        .raddr (COL_W'(x_cur)),
        .rdata (old_dout)
    );

    rgbc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
        .aclk  (aclk),
        .we    (a_valid_reg),
        .waddr (a_x_reg),
        .wdata (a_px_reg),
        .re    (accept),
        .raddr (COL_W'(x_cur)),
        .rdata (new_dout)
    );

    // same column written in the cycle of the read: take the written data
    assign above2 = fwd_reg ? fwd_old_reg : old_dout;
    assign above1 = fwd_reg ? fwd_new_reg : new_dout;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r*3]   = win_reg[r*3+1];
            win_next[r*3+1] = win_reg[r*3+2];
        end
        win_next[2] = above2;
        win_next[5] = above1;
        win_next[8] = a_px_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (a_valid_reg) begin
            win_reg <= win_next;
        end
    end

    assign push                = a_valid_reg;
    assign push_job.win        = win_next;
    assign push_job.row        = a_y_reg;
    assign push_job.col        = a_x_reg;
    assign push_job.interior   = a_int_reg;
    assign push_job.border     = a_bor_reg;
    assign push_job.frame_last = a_fl_reg;

endmodule

// ===== design/rgbc_back.sv =====
// ----------------------------------------------------------------------------
// rgbc_back: convolution datapath and result output
// Multiply, sum, round and clamp stages, then zero, one or two results per job.
// ----------------------------------------------------------------------------
module rgbc_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rgbc_pkg::cfg_t            cfg,
    input  rgbc_pkg::job_t            head_job,
    input  logic [rgbc_pkg::QPTR_W:0] q_count,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [47:0]               m_tdata,   // out_row, out_col, out_red, out_green, out_blue
    output logic                      m_tlast,
    output logic                      m_tuser    // frame_end
);
    import rgbc_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        pixel_t           px;
        logic             interior;
        logic             border;
        logic             frame_last;
    } meta_t;

    logic                                   adv, first;
    logic signed [8:0][2:0][PROD_W-1:0]     prod, p_prod_reg;
    logic signed [2:0][SUM_W-1:0]           sum, s_sum_reg;
    logic [2:0][7:0]                        filt;
    logic signed [SUM_W-1:0]                rnd;
    meta_t                                  head_meta, p_meta_reg, s_meta_reg, o_meta_reg;
    logic                                   p_valid_reg, s_valid_reg, o_valid_reg, o_phase_reg;
    logic [2:0][7:0]                        o_filt_reg;
    logic [ROW_W-1:0]                       out_row;
    logic [COL_W-1:0]                       out_col;
    pixel_t                                 out_pix;

    assign adv = !o_valid_reg || (m_tready && m_tlast);
    assign pop = adv && (q_count != '0);

    assign head_meta.row        = head_job.row;
    assign head_meta.col        = head_job.col;
    assign head_meta.px         = head_job.win[8];
    assign head_meta.interior   = head_job.interior;
    assign head_meta.border     = head_job.border;
    assign head_meta.frame_last = head_job.frame_last;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                for (int ch = 0; ch < 3; ch++) begin
                    prod[r*3+c][ch] = PROD_W'($signed({1'b0, head_job.win[r*3+c][8*ch +: 8]})
                                      * $signed(cfg.coef[r][WGT_W*c +: WGT_W]));
                end
            end
        end
    end

    // element selects are unsigned: sign-extend each product explicitly
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            for (int i = 0; i < 9; i++) begin
                sum[ch] = sum[ch] + SUM_W'($signed(p_prod_reg[i][ch]));
            end
        end
    end

    // round half away from zero, clamp to 0..255
    always_comb begin
        rnd = '0;
        for (int ch = 0; ch < 3; ch++) begin
            rnd = ($signed(s_sum_reg[ch]) + SUM_W'(1 << (COEF_FRAC_BITS - 1)))
                  >>> COEF_FRAC_BITS;
            if ($signed(s_sum_reg[ch]) <= 0) begin
                filt[ch] = '0;
            end else if (rnd > SUM_W'(CHAN_MAX)) begin
                filt[ch] = 8'(CHAN_MAX);
            end else begin
                filt[ch] = rnd[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            o_phase_reg <= 1'b0;
        end else begin
            if (adv) begin
                p_valid_reg <= pop;
                s_valid_reg <= p_valid_reg;
                o_valid_reg <= s_valid_reg && (s_meta_reg.interior || s_meta_reg.border);
                o_phase_reg <= 1'b0;
            end else if (m_tready) begin
                o_phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_prod_reg <= prod;
            p_meta_reg <= head_meta;
            s_sum_reg  <= sum;
            s_meta_reg <= p_meta_reg;
            o_filt_reg <= filt;
            o_meta_reg <= s_meta_reg;
        end
    end

    assign first   = o_meta_reg.interior && !o_phase_reg;
    assign out_row = first ? o_meta_reg.row - ROW_W'(1) : o_meta_reg.row;
    assign out_col = first ? o_meta_reg.col - COL_W'(1) : o_meta_reg.col;
    assign out_pix = first ? o_filt_reg : o_meta_reg.px;

    assign m_tvalid = o_valid_reg;
    assign m_tlast  = first ? !o_meta_reg.border : 1'b1;
    assign m_tuser  = o_meta_reg.frame_last && m_tlast;
    assign m_tdata  = {4'b0, out_pix, COORD_W'(out_col), COORD_W'(out_row)};

endmodule

// ===== design/rgb_3x3_convolution_filter.sv =====
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_filter: streaming 3x3 kernel filter for rgb pixels
//
// Pixels enter in raster order on the s_ channel (s_tdata: red, green, blue).
// Border pixels come back unchanged; each interior pixel (y-1,x-1) comes back
// filtered once pixel (y,x) has been taken, ahead of any border result of
// that transaction. m_tlast marks the last result of an input transaction,
// m_tuser the last result of the frame. The user writes kernel rows and image
// size over the apb port only while the block is idle, not enforced by the block.
// From input to first result a pixel passes intake and line buffer read,
// queue, multiply, sum and round/clamp. One pixel is taken per cycle while
// s_tready is high; a pixel that yields two results (last column or row)
// holds the output stage until both are taken. The four-entry job queue
// absorbs a few of these; along the last row, from the third column on,
// every pixel yields two results and s_tready throttles the input.
// When m_tready is low the back pipeline holds, the queue fills and s_tready
// drops. Reset clears position, queue and valid state; line buffer contents
// are undefined until written and need no clearing.
// ----------------------------------------------------------------------------
module rgb_3x3_convolution_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_red, in_green, in_blue
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_row, out_col, out_red, out_green, out_blue
    output logic        m_tlast,
    output logic        m_tuser,   // frame_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import rgbc_pkg::*;

    cfg_t            cfg_reg;
    logic [2:0]      reg_idx;
    logic            wr_en, push, pop;
    job_t            push_job, head_job;
    logic [QPTR_W:0] q_count;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef[0] <= COEF_TOP_RST;
            cfg_reg.coef[1] <= COEF_MID_RST;
            cfg_reg.coef[2] <= COEF_BOT_RST;
            cfg_reg.width   <= DIM_W'(MAX_WIDTH);
            cfg_reg.height  <= DIM_W'(MAX_HEIGHT);
        end else if (wr_en) begin
            case (reg_idx)
                REG_COEF_TOP: cfg_reg.coef[0] <= pwdata[COEF_W-1:0];
                REG_COEF_MID: cfg_reg.coef[1] <= pwdata[COEF_W-1:0];
                REG_COEF_BOT: cfg_reg.coef[2] <= pwdata[COEF_W-1:0];
                REG_WIDTH:    cfg_reg.width   <= pwdata[DIM_W-1:0];
                REG_HEIGHT:   cfg_reg.height  <= pwdata[DIM_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COEF_TOP: prdata = 64'(cfg_reg.coef[0]);
            REG_COEF_MID: prdata = 64'(cfg_reg.coef[1]);
            REG_COEF_BOT: prdata = 64'(cfg_reg.coef[2]);
            REG_WIDTH:    prdata = 64'(cfg_reg.width);
            REG_HEIGHT:   prdata = 64'(cfg_reg.height);
            default:      prdata = '0;
        endcase
    end

    rgbc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_count  (q_count),
        .push     (push),
        .push_job (push_job)
    );

    rgbc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .count    (q_count)
    );

    rgbc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head_job (head_job),
        .q_count  (q_count),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= (QPTR_W+1)'(QDEPTH))
        else $error("job queue count above depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_count != '0)
        else $error("pop from empty job queue");

    a_frame_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end on a result that is not last of its transaction");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && q_count == '0)
        else $error("output or queue active after reset");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression bench for the rgb 3x3 convolution filter
// Streams raster frames of several sizes and kernels into the block, keeps
// its own line buffers, window and position to work out each result, and
// compares every output transaction field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
    import rgbc_pkg::*;

    typedef struct {
        logic [9:0] row;
        logic [9:0] col;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       run_end;
        logic       frame_end;
    } px_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // in_red, in_green, in_blue
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // out_row, out_col, out_red, out_green, out_blue
    logic        m_tlast;
    logic        m_tuser;         // frame_end
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [5:0]  paddr    = '0;
    logic [63:0] pwdata   = '0;
    logic [63:0] prdata;
    logic        pready;

    rgb_3x3_convolution_filter DUT (.*);

    always #2 aclk = ~aclk;

    // filter state mirror
    logic [23:0]       older_row [MAX_WIDTH];
    logic [23:0]       newer_row [MAX_WIDTH];
    logic [23:0]       win_px [9];
    int                pos_row, pos_col;
    logic [47:0]       kernel [3];
    logic [10:0]       width_reg, height_reg;
    px_result_t        pending_px[$];
    int                err_count;
    int                cycle_count;
    bit                calm;

    localparam int CYCLE_LIMIT = 600000;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 35);
    end

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    // result checker
    always @(posedge aclk) begin
        px_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_px.size() == 0) begin
                report($sformatf("unexpected transaction %h", m_tdata));
            end else begin
                e = pending_px.pop_front();
                if (m_tdata[9:0] !== e.row)
                    report($sformatf("row %0d exp %0d", m_tdata[9:0], e.row));
                if (m_tdata[19:10] !== e.col)
                    report($sformatf("col %0d exp %0d", m_tdata[19:10], e.col));
                if (m_tdata[27:20] !== e.red)
                    report($sformatf("red %0d exp %0d (%0d,%0d)", m_tdata[27:20], e.red,
                                     e.row, e.col));
                if (m_tdata[35:28] !== e.green)
                    report($sformatf("green %0d exp %0d (%0d,%0d)", m_tdata[35:28],
                                     e.green, e.row, e.col));
                if (m_tdata[43:36] !== e.blue)
                    report($sformatf("blue %0d exp %0d (%0d,%0d)", m_tdata[43:36], e.blue,
                                     e.row, e.col));
                if (m_tdata[47:44] !== 4'd0)
                    report("tdata pad bits not zero");
                if (m_tlast !== e.run_end)
                    report($sformatf("tlast %b exp %b", m_tlast, e.run_end));
                if (m_tuser !== e.frame_end)
                    report($sformatf("tuser %b exp %b", m_tuser, e.frame_end));
            end
        end
    end

    function automatic int clip_dim(input logic [10:0] v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic logic [7:0] conv_channel(input int sh);
        longint acc;
        acc = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                acc += longint'(win_px[r*3+c][sh +: 8]) *
                       longint'($signed(kernel[r][16*c +: 16]));
        if (acc <= 0) return 8'd0;
        acc = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        return (acc > CHAN_MAX) ? 8'd255 : acc[7:0];
    endfunction

    function automatic void predict_pixel(input logic [23:0] px);
        int w, h, x, y;
        px_result_t res[$];
        px_result_t o;
        w = clip_dim(width_reg, MAX_WIDTH);
        h = clip_dim(height_reg, MAX_HEIGHT);
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h) pos_row = 0;
        x = pos_col;
        y = pos_row;
        for (int r = 0; r < 3; r++) begin
            win_px[r*3]   = win_px[r*3+1];
            win_px[r*3+1] = win_px[r*3+2];
        end
        win_px[2] = older_row[x];
        win_px[5] = newer_row[x];
        win_px[8] = px;
        older_row[x] = newer_row[x];
        newer_row[x] = px;
        if (y >= 2 && x >= 2) begin
            o.row = 10'(y - 1);
            o.col = 10'(x - 1);
            o.red = conv_channel(0);
            o.green = conv_channel(8);
            o.blue = conv_channel(16);
            o.run_end = 1'b0;
            o.frame_end = 1'b0;
            res.push_back(o);
        end
        if (y == 0 || x == 0 || y == h - 1 || x == w - 1) begin
            o.row = 10'(y);
            o.col = 10'(x);
            {o.blue, o.green, o.red} = px;
            o.run_end = 1'b0;
            o.frame_end = 1'b0;
            res.push_back(o);
        end
        if (res.size() > 0) begin
            res[res.size()-1].run_end = 1'b1;
            res[res.size()-1].frame_end = (y == h - 1 && x == w - 1);
        end
        foreach (res[i]) pending_px.push_back(res[i]);
        if (x + 1 >= w) begin
            pos_col = 0;
            pos_row = (y + 1 >= h) ? 0 : y + 1;
        end else begin
            pos_col = x + 1;
        end
    endfunction

    function automatic bit at_frame_start();
        int r, c;
        r = pos_row;
        c = pos_col;
        if (c >= clip_dim(width_reg, MAX_WIDTH)) begin
            c = 0;
            r++;
        end
        if (r >= clip_dim(height_reg, MAX_HEIGHT)) r = 0;
        return r == 0 && c == 0;
    endfunction

    function automatic logic [23:0] rand_pixel();
        logic [23:0] p;
        p = 24'($urandom);
        case ($urandom_range(0, 7))
            0: p = 24'h000000;
            1: p = 24'hFFFFFF;
            2: p[7:0] = 8'hFF;
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pixel(input logic [23:0] px);
        if (!calm && $urandom_range(0, 99) < 35) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_pixel(px);
    endtask

    // wait until every result is out, plus the pipeline depth
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_px.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx) << 3;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_COEF_TOP: kernel[0] = value[47:0];
            REG_COEF_MID: kernel[1] = value[47:0];
            REG_COEF_BOT: kernel[2] = value[47:0];
            REG_WIDTH:    width_reg = value[10:0];
            REG_HEIGHT:   height_reg = value[10:0];
            default: ;
        endcase
    endtask

    task automatic set_kernel(input logic [47:0] top, input logic [47:0] mid,
                              input logic [47:0] bot);
        apb_write(REG_COEF_TOP, {16'h0, top});
        apb_write(REG_COEF_MID, {16'h0, mid});
        apb_write(REG_COEF_BOT, {16'h0, bot});
    endtask

    task automatic set_size(input logic [10:0] w, input logic [10:0] h);
        apb_write(REG_WIDTH, {53'd0, w});
        apb_write(REG_HEIGHT, {53'd0, h});
    endtask

    task automatic send_frame();
        int n;
        n = clip_dim(width_reg, MAX_WIDTH) * clip_dim(height_reg, MAX_HEIGHT);
        repeat (n) send_pixel(rand_pixel());
        drain();
    endtask

    task automatic test_default_kernel();
        set_size(11'd4, 11'd4);
        send_frame();
    endtask

    task automatic test_coef_extremes();
        set_size(11'd3, 11'd3);
        set_kernel({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        send_frame();
        set_kernel({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        send_frame();
        set_kernel('0, {16'h0, 16'h1000, 16'h0}, '0);
        send_frame();
    endtask

    task automatic test_rounding();
        // half weight on the centre: odd pixels land exactly on .5
        set_kernel('0, {16'h0, 16'h0800, 16'h0}, '0);
        set_size(11'd3, 11'd3);
        for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 24'h0301FF : rand_pixel());
        drain();
    endtask

    task automatic test_size_limits();
        set_size(11'd0, 11'd0);
        send_frame();
        set_size(11'd2, 11'd5);
        send_frame();
        set_size(11'd7, 11'd2);
        send_frame();
        // width clips to the maximum, height of one: all border; the row is
        // then cut short by narrowing the width so its next pixel ends the frame
        set_size(11'd2047, 11'd1);
        repeat (24) send_pixel(rand_pixel());
        drain();
        apb_write(REG_WIDTH, 64'd25);
        send_pixel(rand_pixel());
        drain();
    endtask

    task automatic test_shrink_midframe();
        set_kernel({16'h0F00, 16'hE000, 16'h1800}, {16'h2000, 16'h3000, 16'hF800},
                   {16'h0400, 16'h0900, 16'h1100});
        set_size(11'd8, 11'd6);
        repeat (22) send_pixel(rand_pixel());
        drain();
        apb_write(REG_WIDTH, 64'd4);
        repeat (3) send_pixel(rand_pixel());
        drain();
        apb_write(REG_HEIGHT, 64'd3);
        while (!at_frame_start()) send_pixel(rand_pixel());
        drain();
    endtask

    task automatic test_random_frames();
        int sent;
        sent = 0;
        while (sent < 420) begin
            calm = (sent >= 150 && sent < 230);
            if ($urandom_range(0, 2) == 0)
                set_kernel(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                           48'({$urandom, $urandom}));
            else
                set_kernel({16'($urandom_range(0, 1200)), 16'($urandom_range(0, 1200)),
                            16'($urandom_range(0, 1200))},
                           {16'($urandom_range(0, 1200)), 16'($urandom_range(0, 3000)),
                            16'($urandom_range(0, 1200))},
                           {16'($urandom_range(0, 1200)), 16'($urandom_range(0, 1200)),
                            16'($urandom_range(0, 1200))});
            set_size(11'($urandom_range(1, 12)), 11'($urandom_range(1, 8)));
            sent += clip_dim(width_reg, MAX_WIDTH) * clip_dim(height_reg, MAX_HEIGHT);
            send_frame();
        end
        calm = 1'b0;
    endtask

    initial begin
        err_count   = 0;
        cycle_count = 0;
        calm        = 1'b0;
        pos_row     = 0;
        pos_col     = 0;
        foreach (win_px[i]) win_px[i] = '0;
        foreach (older_row[i]) begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        kernel[0]  = COEF_TOP_RST;
        kernel[1]  = COEF_MID_RST;
        kernel[2]  = COEF_BOT_RST;
        width_reg  = 11'd1024;
        height_reg = 11'd1024;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_kernel();
        test_coef_extremes();
        test_rounding();
        test_size_limits();
        test_shrink_midframe();
        test_random_frames();

        drain();
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
